@@ hdl/cmr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared widths, register indexes and the CRC-16 byte step for the CAN
// message reassembler.
// ----------------------------------------------------------------------------
package cmr_pkg;

    // field widths
    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int PAY_W     = 64;
    localparam int MSG_LEN_W = 10;
    localparam int CODE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 29;

    // default message store depth in 8-byte words
    localparam int MSG_WORDS_DEF = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_ID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMARY_ID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHOTO_CODE = 3'd4;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // result kinds
    localparam logic KIND_CAMERA = 1'b0;
    localparam logic KIND_MSG    = 1'b1;

    // one byte through the CRC, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = b[i] ^ c[15];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/can_message_reassembler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_message_reassembler
// Reassembles multi-frame CAN messages with a CRC-16 check and decodes
// camera trigger commands.
// ----------------------------------------------------------------------------
// One frame is taken at a time. Every frame passes through decode after it is
// accepted, and error, summary, end-mismatch and camera frames free the input
// straight from decode (a camera result waits there if the output register
// is still full). A data frame then goes through S_DATA one payload byte at a
// time, since the CRC advances one byte per cycle and the buffer takes one
// byte lane per write; it stops at the first byte that no longer fits in a
// full buffer, setting the overflow flag. An accepted end frame emits its
// words one at a time via a registered memory read, holding while the output
// is stalled. The memory needs no clearing after reset.
module can_message_reassembler
    import cmr_pkg::*;
#(
    parameter int MSG_WORDS = MSG_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // frame input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_is_error_frame,
    input  logic [ID_W-1:0]      i_frame_id,
    input  logic [LEN_W-1:0]     i_payload_len,
    input  logic [PAY_W-1:0]     i_payload,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic                 o_photo_main,
    output logic                 o_photo_infrared,
    output logic [PAY_W-1:0]     o_msg_word,
    output logic [LEN_W-1:0]     o_word_bytes,
    output logic [MSG_LEN_W-1:0] o_msg_length,
    output logic                 o_last
);

    localparam int CAP   = MSG_WORDS * 8;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int AW    = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DATA   = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    // configuration registers
    logic [ID_W-1:0]   r_camera_id, r_summary_id, r_data_id, r_end_id;
    logic [CODE_W-1:0] r_photo_code;

    // captured frame
    logic              r_err;
    logic [ID_W-1:0]   r_id;
    logic [LEN_W-1:0]  r_len;
    logic [PAY_W-1:0]  r_pay;

    // message state
    logic [31:0]       r_exp_len, n_exp_len;
    logic [15:0]       r_exp_crc, n_exp_crc;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [15:0]       r_crc, n_crc;

    // sequencer
    logic [2:0]        r_state, n_state;
    logic [2:0]        r_idx, n_idx;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_last_k, n_last_k;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_kind, n_kind;
    logic              r_pm, n_pm;
    logic              r_pi, n_pi;
    logic [PAY_W-1:0]  r_word, n_word;
    logic [LEN_W-1:0]  r_nb, n_nb;
    logic [MSG_LEN_W-1:0] r_mlen, n_mlen;
    logic              r_last, n_last;

    // memory ports
    logic              wr_en, rd_en;
    logic [7:0]        wr_byte;
    logic [PAY_W-1:0]  rd_data;

    logic              in_accept;
    logic              out_free;
    logic [LEN_W-1:0]  len_clamp;
    logic [PAY_W-1:0]  pay_mask;
    logic              hit_pm, hit_pi, end_ok;
    logic [CNT_W-1:0]  rem;
    logic [LEN_W-1:0]  nb;
    logic [PAY_W-1:0]  word_mask;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // clamp length, zero absent bytes
    always_comb begin
        len_clamp = (i_payload_len > LEN_W'(8)) ? LEN_W'(8) : i_payload_len;
        for (int i = 0; i < 8; i++) begin
            pay_mask[8*i +: 8] = (LEN_W'(i) < len_clamp) ? i_payload[8*i +: 8] : 8'd0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_id  <= ID_W'(0);
            r_summary_id <= ID_W'(1);
            r_data_id    <= ID_W'(2);
            r_end_id     <= ID_W'(3);
            r_photo_code <= CODE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAMERA_ID:  r_camera_id  <= i_cfg_data;
                CFG_SUMMARY_ID: r_summary_id <= i_cfg_data;
                CFG_DATA_ID:    r_data_id    <= i_cfg_data;
                CFG_END_ID:     r_end_id     <= i_cfg_data;
                CFG_PHOTO_CODE: r_photo_code <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // frame capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_err <= i_is_error_frame;
            r_id  <= i_frame_id;
            r_len <= len_clamp;
            r_pay <= pay_mask;
        end
    end

    // decode helpers
    assign hit_pm = (r_len > LEN_W'(0)) && (r_pay[7:0] == r_photo_code);
    assign hit_pi = (r_len > LEN_W'(1)) && (r_pay[15:8] == r_photo_code);
    assign end_ok = !r_ovf && (32'(r_count) == r_exp_len) && (r_crc == r_exp_crc);

    // word byte count and mask for the word being emitted
    always_comb begin
        rem = r_count - CNT_W'({r_k, 3'b000});
        nb  = (rem >= CNT_W'(8)) ? LEN_W'(8) : LEN_W'(rem);
        for (int i = 0; i < 8; i++) begin
            word_mask[8*i +: 8] = (LEN_W'(i) < nb) ? 8'hFF : 8'h00;
        end
    end

    assign wr_byte = r_pay[{r_idx, 3'b000} +: 8];

    // sequencer and message state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_k         = r_k;
        n_last_k    = r_last_k;
        n_exp_len   = r_exp_len;
        n_exp_crc   = r_exp_crc;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_pm        = r_pm;
        n_pi        = r_pi;
        n_word      = r_word;
        n_nb        = r_nb;
        n_mlen      = r_mlen;
        n_last      = r_last;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (r_err) begin
                    n_state = S_IDLE;
                end else if (r_id == r_camera_id) begin
                    if (!hit_pm && !hit_pi) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_CAMERA;
                        n_pm        = hit_pm;
                        n_pi        = hit_pi;
                        n_word      = '0;
                        n_nb        = '0;
                        n_mlen      = '0;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (r_id == r_summary_id) begin
                    n_exp_len = r_pay[31:0];
                    n_exp_crc = {r_pay[47:40], r_pay[39:32]};
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_crc     = CRC_INIT;
                    n_state   = S_IDLE;
                end else if (r_id == r_data_id) begin
                    n_idx   = '0;
                    n_state = (r_len == LEN_W'(0)) ? S_IDLE : S_DATA;
                end else if (r_id == r_end_id) begin
                    if (!end_ok) begin
                        n_state = S_IDLE;
                    end else if (r_count == '0) begin
                        // empty message: a single word with no bytes
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_MSG;
                            n_pm        = 1'b0;
                            n_pi        = 1'b0;
                            n_word      = '0;
                            n_nb        = '0;
                            n_mlen      = '0;
                            n_last      = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_k      = '0;
                        n_last_k = AW'((r_count - CNT_W'(1)) >> 3);
                        n_state  = S_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DATA: begin
                // one byte per cycle into buffer and CRC
                if (r_count >= CAP_CNT) begin
                    n_ovf   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    wr_en   = 1'b1;
                    n_crc   = crc_byte(r_crc, wr_byte);
                    n_count = r_count + CNT_W'(1);
                    n_idx   = r_idx + 3'd1;
                    if ({1'b0, r_idx} == r_len - LEN_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_MSG;
                    n_pm        = 1'b0;
                    n_pi        = 1'b0;
                    n_word      = rd_data & word_mask;
                    n_nb        = nb;
                    n_mlen      = MSG_LEN_W'(r_count);
                    n_last      = (r_k == r_last_k);
                    if (r_k == r_last_k) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and message state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_exp_len   <= '0;
            r_exp_crc   <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_crc       <= CRC_INIT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_exp_len   <= n_exp_len;
            r_exp_crc   <= n_exp_crc;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_crc       <= n_crc;
        end
    end

    // sequencer counters and output payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_last_k <= n_last_k;
        r_kind   <= n_kind;
        r_pm     <= n_pm;
        r_pi     <= n_pi;
        r_word   <= n_word;
        r_nb     <= n_nb;
        r_mlen   <= n_mlen;
        r_last   <= n_last;
    end

    // message buffer
    cmr_store #(
        .MSG_WORDS (MSG_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_count >> 3)),
        .i_wr_lane (r_count[2:0]),
        .i_wr_byte (wr_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_k),
        .o_rd_data (rd_data)
    );

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_photo_main     = r_pm;
    assign o_photo_infrared = r_pi;
    assign o_msg_word       = r_word;
    assign o_word_bytes     = r_nb;
    assign o_msg_length     = r_mlen;
    assign o_last           = r_last;

    // checks
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_DECODE)
        else $error("accepted frame did not enter decode");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("buffered count above capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CAP_CNT)
        else $error("overflow flag set with buffer not full");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT || r_state == S_RD) |-> r_k <= r_last_k)
        else $error("word index past last word");

endmodule

@@ hdl/cmr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmr_store
// Message buffer: 64-bit words, one byte lane written per cycle,
// registered read port.
// ----------------------------------------------------------------------------
module cmr_store
    import cmr_pkg::*;
#(
    parameter int MSG_WORDS = MSG_WORDS_DEF,
    localparam int AW = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [2:0]       i_wr_lane,
    input  logic [7:0]       i_wr_byte,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [PAY_W-1:0] o_rd_data
);

    logic [PAY_W-1:0] r_mem [MSG_WORDS];
    logic [PAY_W-1:0] r_rd_data;

    // byte-lane write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_byte;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
